// ----- design/tme_pkg.sv -----
// ----------------------------------------------------------------------------
// tme_pkg: shared definitions of the tape machine executor
// Command codes, payload widths and the result record used by the channel
// interfaces and the executor core.
// ----------------------------------------------------------------------------
package tme_pkg;

   localparam int CMD_W    = 4;
   localparam int AMOUNT_W = 17;
   localparam int BYTE_W   = 8;

   // Span of the amount field's magnitude: a negative amount stands for
   // its low sixteen bits minus this value.
   localparam int AMOUNT_SPAN = 65536;

   typedef logic [CMD_W-1:0] command_type;

   localparam command_type CMD_ADD            = 4'd0;
   localparam command_type CMD_MOVE           = 4'd1;
   localparam command_type CMD_OUT            = 4'd2;
   localparam command_type CMD_IN             = 4'd3;
   localparam command_type CMD_LOOP_OPEN      = 4'd4;
   localparam command_type CMD_LOOP_CLOSE     = 4'd5;
   localparam command_type CMD_CLEAR          = 4'd6;
   localparam command_type CMD_MUL            = 4'd7;
   localparam command_type CMD_PTR_END        = 4'd8;
   localparam command_type CMD_PTR_START      = 4'd9;
   localparam command_type CMD_PUSH_VALUE     = 4'd10;
   localparam command_type CMD_POP_VALUE      = 4'd11;
   localparam command_type CMD_PUSH_POINTER   = 4'd12;
   localparam command_type CMD_POP_POINTER    = 4'd13;
   localparam command_type CMD_CLEAR_IF_END   = 4'd14;
   localparam command_type CMD_CLEAR_IF_START = 4'd15;

   typedef struct packed {
      logic              out_valid;
      logic [BYTE_W-1:0] out_byte;
      logic              take_branch;
   } result_type;

endpackage

// ----- design/tme_ifs.sv -----
// ----------------------------------------------------------------------------
// tme_ifs: channel interfaces of the tape machine executor
// Instruction channel and result channel, each with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tme_req_if;
   logic                                valid;
   logic                                ready;
   tme_pkg::command_type                command;
   logic signed [tme_pkg::AMOUNT_W-1:0] amount;
   logic [tme_pkg::BYTE_W-1:0]          factor;
   logic [tme_pkg::BYTE_W-1:0]          in_byte;

   modport source (output valid, command, amount, factor, in_byte, input ready);
   modport sink   (input valid, command, amount, factor, in_byte, output ready);
endinterface

interface tme_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       out_valid;
   logic [tme_pkg::BYTE_W-1:0] out_byte;
   logic                       take_branch;

   modport source (output valid, out_valid, out_byte, take_branch, input ready);
   modport sink   (input valid, out_valid, out_byte, take_branch, output ready);
endinterface

// ----- design/tape_machine_executor.sv -----
// ----------------------------------------------------------------------------
// tape_machine_executor: execution core of an extended tape machine
// Executes one decoded instruction per item against a byte tape, a cell
// pointer, a value stack and a pointer stack, and returns one result item.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one instruction per item (command, amount, factor,
//   in_byte); rsp_chan returns exactly one result item per instruction, in
//   order (out_valid, out_byte, take_branch).
//   An item passes an entry register, a read stage in which the tape and
//   stack memories are read, and an execute stage that writes them back and
//   loads the result register, from which the result is offered.
//   Throughput is one item per cycle while the receiver takes results;
//   a pop_pointer holds the next item until it has left the execute stage,
//   because the next tape address comes from the pointer stack read.
//   Multiply reads the current and the target cell at once from two copies
//   of the tape memory; a write is forwarded to a read of the same cell
//   issued in the same cycle.
//   After reset the tape is zeroed by a pass over all TAPE_CELLS cells, one cell
//   a cycle; items are buffered in the entry register but not executed
//   before the pass ends.
//   When the receiver stalls, the result register holds, the execute stage
//   holds its item, and req_chan.ready drops once the entry register fills.
// ----------------------------------------------------------------------------
module tape_machine_executor #(
   parameter int TAPE_CELLS  = 65536,
   parameter int STACK_DEPTH = 1024
) (
   input logic          clock,
   input logic          reset,
   tme_req_if.sink      req_chan,
   tme_rsp_if.source    rsp_chan
);

   localparam int PW = $clog2(TAPE_CELLS);
   localparam int SW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int BW = tme_pkg::BYTE_W;

   localparam logic [PW+1:0] MOD_N1 = (PW+2)'(TAPE_CELLS);
   localparam logic [PW+1:0] MOD_N2 = (PW+2)'(2 * TAPE_CELLS);
   localparam logic [PW:0]   TGT_N  = (PW+1)'(TAPE_CELLS);
   localparam logic [PW-1:0] NEG_ADJ =
      PW'((TAPE_CELLS - (tme_pkg::AMOUNT_SPAN % TAPE_CELLS)) % TAPE_CELLS);
   localparam logic [PW-1:0] LAST_CELL  = PW'(TAPE_CELLS - 1);
   localparam logic [CW-1:0] STACK_FULL = CW'(STACK_DEPTH);

   // ------------------------------------------------------------------
   // Amount reduced modulo the tape size: (high byte * 256) mod N from a
   // table, plus the low byte, plus a fixed correction for negatives.
   // ------------------------------------------------------------------
   logic [PW-1:0] hi_mod_tab [256];

   for (genvar h = 0; h < 256; h++) begin : g_hi_mod
      localparam logic [PW-1:0] HI_MOD = PW'((h * 256) % TAPE_CELLS);
      assign hi_mod_tab[h] = HI_MOD;
   end

   logic [PW+1:0] amod_sum;
   logic [PW+1:0] amod_red;

   always_comb begin
      amod_sum = (PW+2)'(hi_mod_tab[req_chan.amount[15:8]])
               + (PW+2)'(req_chan.amount[7:0])
               + (req_chan.amount[16] ? (PW+2)'(NEG_ADJ) : (PW+2)'(0));
      if (amod_sum >= MOD_N2) begin
         amod_red = amod_sum - MOD_N2;
      end else if (amod_sum >= MOD_N1) begin
         amod_red = amod_sum - MOD_N1;
      end else begin
         amod_red = amod_sum;
      end
   end

   // ------------------------------------------------------------------
   // Control and state registers
   // ------------------------------------------------------------------
   logic          q_valid_ff,  q_valid_in;
   logic          s2_valid_ff, s2_valid_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0] ptr_ff,      ptr_in;
   logic [CW-1:0] vcnt_ff,     vcnt_in;
   logic [CW-1:0] pcnt_ff,     pcnt_in;
   logic [PW-1:0] clr_addr_ff, clr_addr_in;
   logic          clr_done_ff, clr_done_in;
   logic          tw_valid_ff, tw_valid_in;
   logic          vw_valid_ff, vw_valid_in;

   // Entry register payload
   tme_pkg::command_type q_cmd_ff;
   logic [PW-1:0]        q_amod_ff;
   logic [BW-1:0]        q_amt8_ff;
   logic [BW-1:0]        q_factor_ff;
   logic [BW-1:0]        q_in_byte_ff;

   // Execute stage payload
   tme_pkg::command_type s2_cmd_ff;
   logic [PW-1:0]        s2_ptr_ff;
   logic [PW-1:0]        s2_tgt_ff;
   logic [BW-1:0]        s2_amt8_ff;
   logic [BW-1:0]        s2_factor_ff;
   logic [BW-1:0]        s2_in_byte_ff;
   logic                 s2_stack_ok_ff;
   logic [SW-1:0]        s2_vs_addr_ff;

   // Last write of the tape and of the value stack, for forwarding to a read of the same cycle
   logic [PW-1:0]        tw_addr_ff;
   logic [BW-1:0]        tw_data_ff;
   logic [SW-1:0]        vw_addr_ff;
   logic [BW-1:0]        vw_data_ff;

   tme_pkg::result_type  rsp_ff, rsp_in;

   // ------------------------------------------------------------------
   // Handshake and stage control
   // ------------------------------------------------------------------
   logic req_accept;
   logic s2_adv;
   logic issue;

   assign s2_adv = s2_valid_ff && (!rsp_valid_ff || rsp_chan.ready);

   // The pointer is only known after the execute stage of a pop_pointer.
   assign issue = q_valid_ff && clr_done_ff &&
                  !(s2_valid_ff &&
                    (!s2_adv || s2_cmd_ff == tme_pkg::CMD_POP_POINTER));

   assign req_chan.ready = !q_valid_ff || issue;
   assign req_accept     = req_chan.valid && req_chan.ready;

   // ------------------------------------------------------------------
   // Read stage: addresses, pointer and stack counts
   // ------------------------------------------------------------------
   logic [PW:0]   tgt_sum;
   logic [PW-1:0] tgt_addr;
   logic          vs_push_ok, vs_pop_ok, ps_push_ok, ps_pop_ok;
   logic [SW-1:0] vs_addr;
   logic [SW-1:0] ps_rd_addr;
   logic          ps_wr_en;

   always_comb begin
      tgt_sum = {1'b0, ptr_ff} + {1'b0, q_amod_ff};
      if (tgt_sum >= TGT_N) begin
         tgt_addr = PW'(tgt_sum - TGT_N);
      end else begin
         tgt_addr = PW'(tgt_sum);
      end
   end

   assign vs_push_ok = (vcnt_ff != STACK_FULL);
   assign vs_pop_ok  = (vcnt_ff != '0);
   assign ps_push_ok = (pcnt_ff != STACK_FULL);
   assign ps_pop_ok  = (pcnt_ff != '0);

   assign vs_addr    = (q_cmd_ff == tme_pkg::CMD_PUSH_VALUE) ? vcnt_ff[SW-1:0]
                                                             : SW'(vcnt_ff - 1'b1);
   assign ps_rd_addr = SW'(pcnt_ff - 1'b1);
   assign ps_wr_en   = issue && q_cmd_ff == tme_pkg::CMD_PUSH_POINTER && ps_push_ok;

   // ------------------------------------------------------------------
   // Memories
   // ------------------------------------------------------------------
   logic          tape_wr_en;
   logic [PW-1:0] tape_wr_addr;
   logic [BW-1:0] tape_wr_data;
   logic [BW-1:0] tape_a_rd, tape_b_rd;
   logic          vs_wr_en;
   logic [BW-1:0] vs_rd;
   logic [PW-1:0] ps_rd;

   // Two copies of the tape give the current and the target cell at once.
   tme_ram #(.WIDTH(BW), .DEPTH(TAPE_CELLS)) u_tape_a (
      .clock   (clock),
      .wr_en   (tape_wr_en),
      .wr_addr (tape_wr_addr),
      .wr_data (tape_wr_data),
      .rd_en   (issue),
      .rd_addr (ptr_ff),
      .rd_data (tape_a_rd)
   );

   tme_ram #(.WIDTH(BW), .DEPTH(TAPE_CELLS)) u_tape_b (
      .clock   (clock),
      .wr_en   (tape_wr_en),
      .wr_addr (tape_wr_addr),
      .wr_data (tape_wr_data),
      .rd_en   (issue),
      .rd_addr (tgt_addr),
      .rd_data (tape_b_rd)
   );

   tme_ram #(.WIDTH(BW), .DEPTH(STACK_DEPTH)) u_value_stack (
      .clock   (clock),
      .wr_en   (vs_wr_en),
      .wr_addr (s2_vs_addr_ff),
      .wr_data (tape_wr_data),
      .rd_en   (issue),
      .rd_addr (vs_addr),
      .rd_data (vs_rd)
   );

   tme_ram #(.WIDTH(PW), .DEPTH(STACK_DEPTH)) u_pointer_stack (
      .clock   (clock),
      .wr_en   (ps_wr_en),
      .wr_addr (pcnt_ff[SW-1:0]),
      .wr_data (ptr_ff),
      .rd_en   (issue),
      .rd_addr (ps_rd_addr),
      .rd_data (ps_rd)
   );

   // ------------------------------------------------------------------
   // Execute stage
   // ------------------------------------------------------------------
   logic [BW-1:0] cur_cell;
   logic [BW-1:0] tgt_cell;
   logic [BW-1:0] vs_data;
   logic [BW-1:0] mul_prod;
   logic          s2_wr;
   logic [BW-1:0] s2_wr_data;

   assign cur_cell = (tw_valid_ff && tw_addr_ff == s2_ptr_ff) ? tw_data_ff : tape_a_rd;
   assign tgt_cell = (tw_valid_ff && tw_addr_ff == s2_tgt_ff) ? tw_data_ff : tape_b_rd;
   assign vs_data  = (vw_valid_ff && vw_addr_ff == s2_vs_addr_ff) ? vw_data_ff : vs_rd;
   assign mul_prod = BW'(cur_cell * s2_factor_ff);

   always_comb begin
      s2_wr      = 1'b0;
      s2_wr_data = '0;
      case (s2_cmd_ff)
         tme_pkg::CMD_ADD: begin
            s2_wr      = 1'b1;
            s2_wr_data = cur_cell + s2_amt8_ff;
         end
         tme_pkg::CMD_IN: begin
            s2_wr      = 1'b1;
            s2_wr_data = s2_in_byte_ff;
         end
         tme_pkg::CMD_CLEAR: begin
            s2_wr = 1'b1;
         end
         tme_pkg::CMD_MUL: begin
            s2_wr      = 1'b1;
            s2_wr_data = tgt_cell + mul_prod;
         end
         tme_pkg::CMD_POP_VALUE: begin
            s2_wr      = s2_stack_ok_ff;
            s2_wr_data = vs_data;
         end
         tme_pkg::CMD_PUSH_VALUE: begin
            // Only the value stack is written; its data port shares this mux.
            s2_wr_data = cur_cell;
         end
         tme_pkg::CMD_CLEAR_IF_END: begin
            s2_wr = (s2_ptr_ff == LAST_CELL);
         end
         tme_pkg::CMD_CLEAR_IF_START: begin
            s2_wr = (s2_ptr_ff == '0);
         end
         default: begin
            s2_wr = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (!clr_done_ff) begin
         tape_wr_en   = 1'b1;
         tape_wr_addr = clr_addr_ff;
      end else begin
         tape_wr_en   = s2_adv && s2_wr;
         tape_wr_addr = (s2_cmd_ff == tme_pkg::CMD_MUL) ? s2_tgt_ff : s2_ptr_ff;
      end
   end

   assign tape_wr_data = clr_done_ff ? s2_wr_data : '0;
   assign vs_wr_en     = s2_adv && s2_cmd_ff == tme_pkg::CMD_PUSH_VALUE && s2_stack_ok_ff;

   always_comb begin
      rsp_in.out_valid   = (s2_cmd_ff == tme_pkg::CMD_OUT);
      rsp_in.out_byte    = (s2_cmd_ff == tme_pkg::CMD_OUT) ? cur_cell : '0;
      rsp_in.take_branch = ((s2_cmd_ff == tme_pkg::CMD_LOOP_OPEN)  && cur_cell == '0) ||
                           ((s2_cmd_ff == tme_pkg::CMD_LOOP_CLOSE) && cur_cell != '0);
   end

   // ------------------------------------------------------------------
   // Next state of the control registers
   // ------------------------------------------------------------------
   always_comb begin
      q_valid_in   = req_accept ? 1'b1 : (issue ? 1'b0 : q_valid_ff);
      s2_valid_in  = issue ? 1'b1 : (s2_adv ? 1'b0 : s2_valid_ff);
      rsp_valid_in = s2_adv ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

      clr_addr_in = clr_done_ff ? clr_addr_ff : PW'(clr_addr_ff + 1'b1);
      clr_done_in = clr_done_ff || (clr_addr_ff == LAST_CELL);

      tw_valid_in = tw_valid_ff || (clr_done_ff && tape_wr_en);
      vw_valid_in = vw_valid_ff || vs_wr_en;

      ptr_in  = ptr_ff;
      vcnt_in = vcnt_ff;
      pcnt_in = pcnt_ff;
      if (issue) begin
         case (q_cmd_ff)
            tme_pkg::CMD_MOVE:         ptr_in = tgt_addr;
            tme_pkg::CMD_PTR_END:      ptr_in = LAST_CELL;
            tme_pkg::CMD_PTR_START:    ptr_in = '0;
            tme_pkg::CMD_PUSH_VALUE:   if (vs_push_ok) vcnt_in = vcnt_ff + 1'b1;
            tme_pkg::CMD_POP_VALUE:    if (vs_pop_ok)  vcnt_in = vcnt_ff - 1'b1;
            tme_pkg::CMD_PUSH_POINTER: if (ps_push_ok) pcnt_in = pcnt_ff + 1'b1;
            tme_pkg::CMD_POP_POINTER:  if (ps_pop_ok)  pcnt_in = pcnt_ff - 1'b1;
            default: begin
            end
         endcase
      end
      if (s2_adv && s2_cmd_ff == tme_pkg::CMD_POP_POINTER && s2_stack_ok_ff) begin
         ptr_in = ps_rd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_valid_ff   <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ptr_ff       <= '0;
         vcnt_ff      <= '0;
         pcnt_ff      <= '0;
         clr_addr_ff  <= '0;
         clr_done_ff  <= 1'b0;
         tw_valid_ff  <= 1'b0;
         vw_valid_ff  <= 1'b0;
      end else begin
         q_valid_ff   <= q_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         ptr_ff       <= ptr_in;
         vcnt_ff      <= vcnt_in;
         pcnt_ff      <= pcnt_in;
         clr_addr_ff  <= clr_addr_in;
         clr_done_ff  <= clr_done_in;
         tw_valid_ff  <= tw_valid_in;
         vw_valid_ff  <= vw_valid_in;
      end
   end

   // ------------------------------------------------------------------
   // Payload registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_accept) begin
         q_cmd_ff     <= req_chan.command;
         q_amod_ff    <= PW'(amod_red);
         q_amt8_ff    <= req_chan.amount[7:0];
         q_factor_ff  <= req_chan.factor;
         q_in_byte_ff <= req_chan.in_byte;
      end
      if (issue) begin
         s2_cmd_ff      <= q_cmd_ff;
         s2_ptr_ff      <= ptr_ff;
         s2_tgt_ff      <= tgt_addr;
         s2_amt8_ff     <= q_amt8_ff;
         s2_factor_ff   <= q_factor_ff;
         s2_in_byte_ff  <= q_in_byte_ff;
         s2_vs_addr_ff  <= vs_addr;
         case (q_cmd_ff)
            tme_pkg::CMD_PUSH_VALUE:  s2_stack_ok_ff <= vs_push_ok;
            tme_pkg::CMD_POP_VALUE:   s2_stack_ok_ff <= vs_pop_ok;
            tme_pkg::CMD_POP_POINTER: s2_stack_ok_ff <= ps_pop_ok;
            default:                  s2_stack_ok_ff <= 1'b0;
         endcase
      end
      if (clr_done_ff && tape_wr_en) begin
         tw_addr_ff <= tape_wr_addr;
         tw_data_ff <= tape_wr_data;
      end
      if (vs_wr_en) begin
         vw_addr_ff <= s2_vs_addr_ff;
         vw_data_ff <= tape_wr_data;
      end
      if (s2_adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.out_valid   = rsp_ff.out_valid;
   assign rsp_chan.out_byte    = rsp_ff.out_byte;
   assign rsp_chan.take_branch = rsp_ff.take_branch;

endmodule

// ----- design/tme_ram.sv -----
// ----------------------------------------------------------------------------
// tme_ram: generic single-port-write, single-port-read memory
// One write and one read per cycle; read data is registered and holds
// while no read is enabled.
// ----------------------------------------------------------------------------
module tme_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
